/* rtl/owtr_pkg.sv */
// Package for the one-wire temperature reader: phase and command codes,
// configuration and state types, reset values and the command byte table.
// No dependencies; used by owtr_step and one_wire_temperature_reader.
package owtr_pkg;

    // Bus sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_LOW   = 4'd1,
        PH_RST_REL   = 4'd2,
        PH_PRES_WAIT = 4'd3,
        PH_PRES_END  = 4'd4,
        PH_WR_LOW    = 4'd5,
        PH_WR_REL    = 4'd6,
        PH_RD_LOW    = 4'd7,
        PH_RD_WAIT   = 4'd8,
        PH_RD_TAIL   = 4'd9
    } t_phase;

    // Request commands
    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_TEMP = 2'd1,
        CMD_PRES = 2'd2,
        CMD_RSVD = 2'd3
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_RESET_LOW     = 3'd0,
        CFG_RESET_RELEASE = 3'd1,
        CFG_PRES_WAIT     = 3'd2,
        CFG_PRES_END      = 3'd3,
        CFG_SHORT_LOW     = 3'd4,
        CFG_LONG_LOW      = 3'd5,
        CFG_READ_SAMPLE   = 3'd6,
        CFG_READ_TAIL     = 3'd7
    } t_cfg_idx;

    // Byte steps with special meaning in the command sequence
    localparam logic [2:0] STEP_SECOND_RESET = 3'd2;
    localparam logic [2:0] STEP_READ_LOW     = 3'd4;
    localparam logic [2:0] STEP_READ_HIGH    = 3'd5;

    // Configuration reset values
    localparam logic [9:0] RESET_LOW_DEF     = 10'd750;
    localparam logic [7:0] RESET_RELEASE_DEF = 8'd15;
    localparam logic [9:0] PRES_WAIT_DEF     = 10'd200;
    localparam logic [9:0] PRES_END_DEF      = 10'd240;
    localparam logic [7:0] SHORT_LOW_DEF     = 8'd2;
    localparam logic [7:0] LONG_LOW_DEF      = 8'd60;
    localparam logic [7:0] READ_SAMPLE_DEF   = 8'd12;
    localparam logic [7:0] READ_TAIL_DEF     = 8'd50;

    // Command bytes
    localparam logic [7:0] BYTE_SKIP_ROM  = 8'hCC;
    localparam logic [7:0] BYTE_CONVERT   = 8'h44;
    localparam logic [7:0] BYTE_READ_SCR  = 8'hBE;

    // Temperature saturation limits
    localparam logic [11:0] TEMP_MAX = 12'h7FF;
    localparam logic [11:0] TEMP_MIN = 12'h800;

    typedef struct packed {
        logic [9:0] reset_low;
        logic [7:0] reset_release;
        logic [9:0] pres_wait;
        logic [9:0] pres_end;
        logic [7:0] short_low;
        logic [7:0] long_low;
        logic [7:0] read_sample;
        logic [7:0] read_tail;
    } t_cfg;

    typedef struct packed {
        t_phase     phase;
        logic [9:0] tick_count;
        logic [2:0] bit_index;
        logic [2:0] byte_step;
        logic [7:0] shift_byte;
        logic [7:0] low_byte;
        logic       absent_flag;
        logic       job_kind;
    } t_state;

    typedef struct packed {
        logic        drive_low;
        logic        busy_res;
        logic        done_res;
        logic        device_absent;
        logic [11:0] temperature;
        logic        temperature_valid;
    } t_result;

    // Byte written at each step of the command sequence
    function automatic logic [7:0] cmd_byte(input logic [2:0] step);
        logic [7:0] b;
        case (step)
            3'd0:    b = BYTE_SKIP_ROM;
            3'd1:    b = BYTE_CONVERT;
            3'd2:    b = BYTE_SKIP_ROM;
            3'd3:    b = BYTE_READ_SCR;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* rtl/owtr_step.sv */
// Per-tick next-state and result logic of the one-wire sequencer.
// Depends on owtr_pkg for the state, configuration and result types.
module owtr_step
    import owtr_pkg::*;
(
    input  t_state     i_state,
    input  t_cfg       i_cfg,
    input  logic [1:0] i_cmd,
    input  logic       i_line_level,
    output t_state     o_state,
    output t_result    o_result
);

    t_state      s;
    t_result     r;
    logic [9:0]  tc_inc;
    logic [15:0] raw;
    logic        pres_exit;

    always_comb begin
        s  = i_state;
        r  = '0;
        raw = '0;
        pres_exit = 1'b0;

        // Start a job from idle; the start item is the first reset-low tick
        if (s.phase == PH_IDLE && (i_cmd == CMD_TEMP || i_cmd == CMD_PRES)) begin
            s.job_kind    = (i_cmd == CMD_TEMP);
            s.absent_flag = 1'b0;
            s.byte_step   = '0;
            s.bit_index   = '0;
            s.shift_byte  = '0;
            s.low_byte    = '0;
            s.phase       = PH_RST_LOW;
            s.tick_count  = '0;
        end

        tc_inc = s.tick_count + 10'd1;

        case (s.phase)
            PH_IDLE: begin
                s.tick_count = '0;
            end
            PH_RST_LOW: begin
                r.drive_low  = 1'b1;
                s.tick_count = tc_inc;
                if (tc_inc >= i_cfg.reset_low) begin
                    s.phase      = PH_RST_REL;
                    s.tick_count = '0;
                end
            end
            PH_RST_REL: begin
                s.tick_count = tc_inc;
                if (tc_inc >= {2'b00, i_cfg.reset_release}) begin
                    s.phase      = PH_PRES_WAIT;
                    s.tick_count = '0;
                end
            end
            PH_PRES_WAIT, PH_PRES_END: begin
                // Wait counts high samples; a low sample opens the end phase
                if (s.phase == PH_PRES_WAIT && i_line_level) begin
                    s.tick_count = tc_inc;
                    if (tc_inc >= i_cfg.pres_wait) begin
                        s.absent_flag = 1'b1;
                        pres_exit     = 1'b1;
                    end
                end else if (s.phase == PH_PRES_WAIT) begin
                    s.phase      = PH_PRES_END;
                    s.tick_count = 10'd1;
                    if (10'd1 >= i_cfg.pres_end) begin
                        s.absent_flag = 1'b1;
                        pres_exit     = 1'b1;
                    end
                end else if (!i_line_level) begin
                    s.tick_count = tc_inc;
                    if (tc_inc >= i_cfg.pres_end) begin
                        s.absent_flag = 1'b1;
                        pres_exit     = 1'b1;
                    end
                end else begin
                    pres_exit = 1'b1;
                end
                // Leave the check on timeout or on the end of the pulse
                if (pres_exit) begin
                    s.tick_count = '0;
                    if (s.job_kind) begin
                        s.shift_byte = cmd_byte(s.byte_step);
                        s.bit_index  = '0;
                        s.phase      = PH_WR_LOW;
                    end else begin
                        s.phase    = PH_IDLE;
                        r.done_res = 1'b1;
                    end
                end
            end
            PH_WR_LOW: begin
                r.drive_low  = 1'b1;
                s.tick_count = tc_inc;
                if (tc_inc >= {2'b00, (s.shift_byte[0] ? i_cfg.short_low : i_cfg.long_low)})
                begin
                    s.phase      = PH_WR_REL;
                    s.tick_count = '0;
                end
            end
            PH_WR_REL: begin
                s.tick_count = tc_inc;
                if (tc_inc >= {2'b00, (s.shift_byte[0] ? i_cfg.long_low : 8'd1)}) begin
                    s.shift_byte = {1'b0, s.shift_byte[7:1]};
                    s.tick_count = '0;
                    if (s.bit_index == 3'd7) begin
                        s.byte_step = s.byte_step + 3'd1;
                        s.bit_index = '0;
                        if (s.byte_step == STEP_SECOND_RESET) begin
                            s.phase = PH_RST_LOW;
                        end else if (s.byte_step >= STEP_READ_LOW) begin
                            s.shift_byte = '0;
                            s.phase      = PH_RD_LOW;
                        end else begin
                            s.shift_byte = cmd_byte(s.byte_step);
                            s.phase      = PH_WR_LOW;
                        end
                    end else begin
                        s.bit_index = s.bit_index + 3'd1;
                        s.phase     = PH_WR_LOW;
                    end
                end
            end
            PH_RD_LOW: begin
                r.drive_low  = 1'b1;
                s.tick_count = tc_inc;
                if (tc_inc >= {2'b00, i_cfg.short_low}) begin
                    s.phase      = PH_RD_WAIT;
                    s.tick_count = '0;
                end
            end
            PH_RD_WAIT: begin
                s.tick_count = tc_inc;
                if (tc_inc >= {2'b00, i_cfg.read_sample}) begin
                    s.phase      = PH_RD_TAIL;
                    s.tick_count = '0;
                end
            end
            PH_RD_TAIL: begin
                // Sample on the first tail tick, LSB first
                if (s.tick_count == '0) s.shift_byte = {i_line_level, s.shift_byte[7:1]};
                s.tick_count = tc_inc;
                if (tc_inc >= {2'b00, i_cfg.read_tail}) begin
                    s.tick_count = '0;
                    if (s.bit_index == 3'd7) begin
                        if (s.byte_step == STEP_READ_LOW) begin
                            s.low_byte   = s.shift_byte;
                            s.byte_step  = STEP_READ_HIGH;
                            s.shift_byte = '0;
                            s.bit_index  = '0;
                            s.phase      = PH_RD_LOW;
                        end else begin
                            s.phase    = PH_IDLE;
                            r.done_res = 1'b1;
                            if (s.job_kind) begin
                                // Saturate the signed 16-bit reading to 12 bits
                                raw = {s.shift_byte, s.low_byte};
                                if (!raw[15] && raw[14:11] != 4'h0) begin
                                    r.temperature = TEMP_MAX;
                                end else if (raw[15] && raw[14:11] != 4'hF) begin
                                    r.temperature = TEMP_MIN;
                                end else begin
                                    r.temperature = raw[11:0];
                                end
                                r.temperature_valid = !s.absent_flag;
                            end
                        end
                    end else begin
                        s.bit_index = s.bit_index + 3'd1;
                        s.phase     = PH_RD_LOW;
                    end
                end
            end
            default: begin
                s.phase      = PH_IDLE;
                s.tick_count = '0;
            end
        endcase

        r.busy_res      = (s.phase != PH_IDLE);
        r.device_absent = s.absent_flag;
        o_state  = s;
        o_result = r;
    end

endmodule

/* rtl/one_wire_temperature_reader.sv */
// Top level of the one-wire temperature reader: configuration registers,
// sequencer state, output register. Uses owtr_pkg and owtr_step.
// Results are registered: a result appears in the output register in the cycle after its request is accepted.
// Throughput: one request per cycle while o_stall is low; the sequencer advances one tick per request.
// A stalled output holds its result; input stalls only while that result waits.
// Reset: synchronous, active low; sequencer idle, configuration at defaults.
module one_wire_temperature_reader
    import owtr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic        i_line_level,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_drive_low,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic        o_device_absent,
    output logic signed [11:0] o_temperature,
    output logic        o_temperature_valid,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result r_out;
    t_result n_out;
    logic    r_out_valid;
    logic    in_take;

    // Accept a request when the output register is free or drains now
    assign o_stall     = r_out_valid && i_stall;
    assign in_take     = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    owtr_step u_step (
        .i_state      (r_state),
        .i_cfg        (r_cfg),
        .i_cmd        (i_cmd),
        .i_line_level (i_line_level),
        .o_state      (n_state),
        .o_result     (n_out)
    );

    // Configuration registers, truncated to their widths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low     <= RESET_LOW_DEF;
            r_cfg.reset_release <= RESET_RELEASE_DEF;
            r_cfg.pres_wait     <= PRES_WAIT_DEF;
            r_cfg.pres_end      <= PRES_END_DEF;
            r_cfg.short_low     <= SHORT_LOW_DEF;
            r_cfg.long_low      <= LONG_LOW_DEF;
            r_cfg.read_sample   <= READ_SAMPLE_DEF;
            r_cfg.read_tail     <= READ_TAIL_DEF;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_RESET_LOW:     r_cfg.reset_low     <= i_cfg_data;
                CFG_RESET_RELEASE: r_cfg.reset_release <= i_cfg_data[7:0];
                CFG_PRES_WAIT:     r_cfg.pres_wait     <= i_cfg_data;
                CFG_PRES_END:      r_cfg.pres_end      <= i_cfg_data;
                CFG_SHORT_LOW:     r_cfg.short_low     <= i_cfg_data[7:0];
                CFG_LONG_LOW:      r_cfg.long_low      <= i_cfg_data[7:0];
                CFG_READ_SAMPLE:   r_cfg.read_sample   <= i_cfg_data[7:0];
                CFG_READ_TAIL:     r_cfg.read_tail     <= i_cfg_data[7:0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    // Advance the sequencer on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_IDLE, default: '0};
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    // Output register: load on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_out <= n_out;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_drive_low         = r_out.drive_low;
    assign o_busy_res          = r_out.busy_res;
    assign o_done_res          = r_out.done_res;
    assign o_device_absent     = r_out.device_absent;
    assign o_temperature       = r_out.temperature;
    assign o_temperature_valid = r_out.temperature_valid;

    // A fresh reading only comes with the end of a job
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_temperature_valid |-> o_done_res && !o_busy_res)
        else $error("temperature valid outside job end");

    // A reading is never marked fresh when the device was absent
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_temperature_valid |-> !o_device_absent)
        else $error("temperature valid with absent device");

    // The bus is released whenever no job runs
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_busy_res |-> !o_drive_low)
        else $error("bus driven while idle");

    // A finished job leaves the sequencer idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take && n_out.done_res |=> r_state.phase == PH_IDLE)
        else $error("sequencer not idle after job end");

endmodule
